@@ rtl/core/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// Quaternion to Euler angles package
// Shared types, widths and the arctangent step table used by the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

   localparam int TERM_W = 34;
   localparam int ACC_W  = 34;
   localparam int RAD_W  = 62;
   localparam int ROOT_W = 31;
   localparam int REM_W  = 34;
   localparam int SQRT_STAGES = 31;
   localparam int NUM_LANES = 3;

   localparam logic signed [TERM_W-1:0] ONE_Q30 = 34'sd1073741824;
   localparam logic signed [ACC_W-1:0]  PI_BA   = 34'sd2147483648;
   localparam logic signed [ACC_W-1:0]  ROUND_HALF = 34'sd32768;
   localparam logic [RAD_W-1:0] ONE_Q60 = 62'h1000_0000_0000_0000;
   localparam logic signed [15:0] PITCH_POS = 16'sh4000;
   localparam logic signed [15:0] PITCH_NEG = 16'shC000;

   localparam int LANE_ROLL  = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_YAW   = 2;

   localparam logic signed [ACC_W-1:0] ATAN_TAB [32] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81,
      34'sd41,        34'sd20,        34'sd10,        34'sd5,
      34'sd3,         34'sd1,         34'sd1,         34'sd0
   };

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic               pitch_saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [TERM_W-1:0] sinr;
      logic signed [TERM_W-1:0] cosr;
      logic signed [TERM_W-1:0] sinp;
      logic signed [TERM_W-1:0] siny;
      logic signed [TERM_W-1:0] cosy;
      logic                     sat;
   } side_type;

endpackage

`default_nettype wire

@@ rtl/core/qte_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one bit of an integer square root per stage, restoring style.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_sqrt_cell #(
   parameter int K = 30
) (
   input  wire logic                          clock,
   input  wire logic [qte_pkg::RAD_W-1:0]     rad_prev,
   input  wire logic [qte_pkg::ROOT_W-1:0]    res_prev,
   input  wire logic [qte_pkg::REM_W-1:0]     rem_prev,
   output logic      [qte_pkg::RAD_W-1:0]     rad_next,
   output logic      [qte_pkg::ROOT_W-1:0]    res_next,
   output logic      [qte_pkg::REM_W-1:0]     rem_next
);
   import qte_pkg::*;

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W-1:0] res_ff, res_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W+1:0]  rem_sh, trial;
   logic              ge;

   always_comb begin
      rem_sh = {rem_prev, rad_prev[2*K+1 -: 2]};
      trial  = {3'b000, res_prev, 2'b01};
      ge     = (rem_sh >= trial);
      rem_in = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      res_in = {res_prev[ROOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_prev;
      res_ff <= res_in;
      rem_ff <= rem_in;
   end

   assign rad_next = rad_ff;
   assign res_next = res_ff;
   assign rem_next = rem_ff;

endmodule

`default_nettype wire

@@ rtl/core/qte_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation toward the x axis with angle accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic_cell #(
   parameter int STAGE = 0,
   parameter int CW    = 21
) (
   input  wire logic                             clock,
   input  wire logic signed [CW-1:0]             x_prev,
   input  wire logic signed [CW-1:0]             y_prev,
   input  wire logic signed [qte_pkg::ACC_W-1:0] acc_prev,
   input  wire logic                             zero_prev,
   output logic signed [CW-1:0]                  x_next,
   output logic signed [CW-1:0]                  y_next,
   output logic signed [qte_pkg::ACC_W-1:0]      acc_next,
   output logic                                  zero_next
);
   import qte_pkg::*;

   logic signed [CW-1:0]    x_ff, y_ff, x_in, y_in, dx, dy;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    zero_ff;

   always_comb begin
      dx = y_prev >>> STAGE;
      dy = x_prev >>> STAGE;
      if (y_prev >= 0) begin
         x_in   = x_prev + dx;
         y_in   = y_prev - dy;
         acc_in = acc_prev + ATAN_TAB[STAGE];
      end else begin
         x_in   = x_prev - dx;
         y_in   = y_prev + dy;
         acc_in = acc_prev - ATAN_TAB[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      zero_ff <= zero_prev;
   end

   assign x_next    = x_ff;
   assign y_next    = y_ff;
   assign acc_next  = acc_ff;
   assign zero_next = zero_ff;

endmodule

`default_nettype wire

@@ rtl/core/quaternion_to_euler_zyx.sv @@
// ----------------------------------------------------------------------------
// Quaternion to ZYX Euler angles
// Products, a pipelined square root and three CORDIC chains of cells.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; each sqrt and CORDIC stage is a cell register.
// The square root chain resolves one result bit per cell.
// busy is always low. Reset clears only the valid pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_zyx #(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int ROTATION_STAGES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire qte_pkg::req_type req_data,
   output logic                  busy,
   output logic                  rsp_strobe,
   output qte_pkg::rsp_type      rsp_data
);
   import qte_pkg::*;

   localparam int CW  = SAMPLE_WIDTH + 5;
   localparam int NS  = ROTATION_STAGES;
   localparam int SHR = (SAMPLE_WIDTH <= 31) ? (31 - SAMPLE_WIDTH) : 0;
   localparam int SHL = (SAMPLE_WIDTH <= 31) ? 0 : 1;

   logic accept;
   logic signed [31:0] p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_wy_ff;
   logic signed [31:0] p_zx_ff, p_wz_ff, p_xy_ff, p_zz_ff;
   logic v_mul_ff, v_sum_ff, v_sq_ff;
   side_type side_in, side_s1_ff, side_s2_ff;
   logic signed [TERM_W-1:0] abs_sinp;
   logic [29:0] sq_in, sq_s1_ff;
   logic [59:0] sqsq_ff;
   logic [RAD_W-1:0] rad0_ff;

   wire logic [RAD_W-1:0]  sq_rad [0:SQRT_STAGES];
   wire logic [ROOT_W-1:0] sq_res [0:SQRT_STAGES];
   wire logic [REM_W-1:0]  sq_rem [0:SQRT_STAGES];
   side_type side_ff [0:SQRT_STAGES];
   logic     sv_ff   [0:SQRT_STAGES];

   logic signed [TERM_W-1:0] ty [NUM_LANES];
   logic signed [TERM_W-1:0] tx [NUM_LANES];
   logic signed [CW-1:0]     sx [NUM_LANES];
   logic signed [CW-1:0]     sy [NUM_LANES];
   logic signed [CW-1:0]     px_in [NUM_LANES];
   logic signed [CW-1:0]     py_in [NUM_LANES];
   logic signed [ACC_W-1:0]  pacc_in [NUM_LANES];
   logic                     pz_in [NUM_LANES];
   logic signed [CW-1:0]     px_ff [NUM_LANES];
   logic signed [CW-1:0]     py_ff [NUM_LANES];
   logic signed [ACC_W-1:0]  pacc_ff [NUM_LANES];
   logic                     pz_ff [NUM_LANES];

   wire logic signed [CW-1:0]    cx_q   [0:NS][NUM_LANES];
   wire logic signed [CW-1:0]    cy_q   [0:NS][NUM_LANES];
   wire logic signed [ACC_W-1:0] cacc_q [0:NS][NUM_LANES];
   wire logic                    cz_q   [0:NS][NUM_LANES];
   logic cv_ff   [0:NS];
   logic psat_ff [0:NS];
   logic pneg_ff [0:NS];

   logic signed [ACC_W-1:0] rnd [NUM_LANES];
   logic [15:0]             ang [NUM_LANES];
   rsp_type rsp_in, rsp_data_ff;
   logic    rsp_strobe_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      p_wx_ff <= 32'(req_data.quat_w) * 32'(req_data.quat_x);
      p_yz_ff <= 32'(req_data.quat_y) * 32'(req_data.quat_z);
      p_xx_ff <= 32'(req_data.quat_x) * 32'(req_data.quat_x);
      p_yy_ff <= 32'(req_data.quat_y) * 32'(req_data.quat_y);
      p_wy_ff <= 32'(req_data.quat_w) * 32'(req_data.quat_y);
      p_zx_ff <= 32'(req_data.quat_z) * 32'(req_data.quat_x);
      p_wz_ff <= 32'(req_data.quat_w) * 32'(req_data.quat_z);
      p_xy_ff <= 32'(req_data.quat_x) * 32'(req_data.quat_y);
      p_zz_ff <= 32'(req_data.quat_z) * 32'(req_data.quat_z);
   end

   always_comb begin
      side_in.sinr = (TERM_W'(p_wx_ff) + TERM_W'(p_yz_ff)) <<< 1;
      side_in.cosr = ONE_Q30 - ((TERM_W'(p_xx_ff) + TERM_W'(p_yy_ff)) <<< 1);
      side_in.sinp = (TERM_W'(p_wy_ff) - TERM_W'(p_zx_ff)) <<< 1;
      side_in.siny = (TERM_W'(p_wz_ff) + TERM_W'(p_xy_ff)) <<< 1;
      side_in.cosy = ONE_Q30 - ((TERM_W'(p_yy_ff) + TERM_W'(p_zz_ff)) <<< 1);
      side_in.sat  = (side_in.sinp >= ONE_Q30) || (side_in.sinp <= -ONE_Q30);
      abs_sinp     = side_in.sinp[TERM_W-1] ? -side_in.sinp : side_in.sinp;
      sq_in        = abs_sinp[29:0];
   end

   always_ff @(posedge clock) begin
      side_s1_ff <= side_in;
      sq_s1_ff   <= sq_in;
      side_s2_ff <= side_s1_ff;
      sqsq_ff    <= 60'(sq_s1_ff) * 60'(sq_s1_ff);
      rad0_ff    <= ONE_Q60 - RAD_W'(sqsq_ff);
      side_ff[0] <= side_s2_ff;
      for (int j = 0; j < SQRT_STAGES; j++) begin
         side_ff[j+1] <= side_ff[j];
      end
   end

   assign sq_rad[0] = rad0_ff;
   assign sq_res[0] = '0;
   assign sq_rem[0] = '0;

   for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
      qte_sqrt_cell #(
         .K(SQRT_STAGES - 1 - j)
      ) u_cell (
         .clock    (clock),
         .rad_prev (sq_rad[j]),
         .res_prev (sq_res[j]),
         .rem_prev (sq_rem[j]),
         .rad_next (sq_rad[j+1]),
         .res_next (sq_res[j+1]),
         .rem_next (sq_rem[j+1])
      );
   end

   always_comb begin
      ty[LANE_ROLL]  = side_ff[SQRT_STAGES].sinr;
      tx[LANE_ROLL]  = side_ff[SQRT_STAGES].cosr;
      ty[LANE_PITCH] = side_ff[SQRT_STAGES].sinp;
      tx[LANE_PITCH] = $signed({3'b000, sq_res[SQRT_STAGES]});
      ty[LANE_YAW]   = side_ff[SQRT_STAGES].siny;
      tx[LANE_YAW]   = side_ff[SQRT_STAGES].cosy;
      for (int l = 0; l < NUM_LANES; l++) begin
         sx[l]    = CW'(tx[l] >>> SHR) <<< SHL;
         sy[l]    = CW'(ty[l] >>> SHR) <<< SHL;
         pz_in[l] = (tx[l] == '0) && (ty[l] == '0);
         if (sx[l] < 0) begin
            pacc_in[l] = (sy[l] >= 0) ? PI_BA : -PI_BA;
            px_in[l]   = -sx[l];
            py_in[l]   = -sy[l];
         end else begin
            pacc_in[l] = '0;
            px_in[l]   = sx[l];
            py_in[l]   = sy[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff      <= px_in;
      py_ff      <= py_in;
      pacc_ff    <= pacc_in;
      pz_ff      <= pz_in;
      psat_ff[0] <= side_ff[SQRT_STAGES].sat;
      pneg_ff[0] <= side_ff[SQRT_STAGES].sinp[TERM_W-1];
      for (int s = 0; s < NS; s++) begin
         psat_ff[s+1] <= psat_ff[s];
         pneg_ff[s+1] <= pneg_ff[s];
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      assign cx_q[0][l]   = px_ff[l];
      assign cy_q[0][l]   = py_ff[l];
      assign cacc_q[0][l] = pacc_ff[l];
      assign cz_q[0][l]   = pz_ff[l];
      for (genvar s = 0; s < NS; s++) begin : g_stage
         qte_cordic_cell #(
            .STAGE (s),
            .CW    (CW)
         ) u_cell (
            .clock     (clock),
            .x_prev    (cx_q[s][l]),
            .y_prev    (cy_q[s][l]),
            .acc_prev  (cacc_q[s][l]),
            .zero_prev (cz_q[s][l]),
            .x_next    (cx_q[s+1][l]),
            .y_next    (cy_q[s+1][l]),
            .acc_next  (cacc_q[s+1][l]),
            .zero_next (cz_q[s+1][l])
         );
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         rnd[l] = cacc_q[NS][l] + ROUND_HALF;
         ang[l] = cz_q[NS][l] ? 16'h0000 : rnd[l][31:16];
      end
      rsp_in.roll_angle      = ang[LANE_ROLL];
      rsp_in.yaw_angle       = ang[LANE_YAW];
      rsp_in.pitch_saturated = psat_ff[NS];
      if (psat_ff[NS]) begin
         rsp_in.pitch_angle = pneg_ff[NS] ? PITCH_NEG : PITCH_POS;
      end else begin
         rsp_in.pitch_angle = ang[LANE_PITCH];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_mul_ff      <= 1'b0;
         v_sum_ff      <= 1'b0;
         v_sq_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int j = 0; j <= SQRT_STAGES; j++) begin
            sv_ff[j] <= 1'b0;
         end
         for (int s = 0; s <= NS; s++) begin
            cv_ff[s] <= 1'b0;
         end
      end else begin
         v_mul_ff <= accept;
         v_sum_ff <= v_mul_ff;
         v_sq_ff  <= v_sum_ff;
         sv_ff[0] <= v_sq_ff;
         for (int j = 0; j < SQRT_STAGES; j++) begin
            sv_ff[j+1] <= sv_ff[j];
         end
         cv_ff[0] <= sv_ff[SQRT_STAGES];
         for (int s = 0; s < NS; s++) begin
            cv_ff[s+1] <= cv_ff[s];
         end
         rsp_strobe_ff <= cv_ff[NS];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

@@ verif/tb_quaternion_to_euler_zyx.sv @@
// ----------------------------------------------------------------------------
// Quaternion to ZYX Euler angles testbench
// Drives quaternions through the command port and checks roll, pitch, yaw and
// the saturation flag of every transaction against a bit-exact fixed-point
// model of the CORDIC datapath kept inside the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quaternion_to_euler_zyx;
   import qte_pkg::*;

   localparam int  STAGES     = 16;
   localparam int  SAMPLE_SH  = 15;
   localparam int  LATENCY    = 53;
   localparam int  IDLE_LIMIT = 4000;
   localparam longint Q30     = 64'sd1 << 30;
   localparam longint PI_ANG  = 64'sd1 << 31;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rsp_type angles_due[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      last_activity = 0;
   int      send_idle_pct = 0;

   quaternion_to_euler_zyx u_top (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   function automatic logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [15:0] cordic_angle(longint y, longint x);
      longint acc;
      longint cx;
      longint cy;
      longint dx;
      longint dy;
      longint step;
      acc = 0;
      if (x == 0 && y == 0) return 16'd0;
      cx = x >>> SAMPLE_SH;
      cy = y >>> SAMPLE_SH;
      if (cx < 0) begin
         acc = (cy >= 0) ? PI_ANG : -PI_ANG;
         cx = -cx;
         cy = -cy;
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         step = longint'(ATAN_TAB[i]);
         if (cy >= 0) begin
            cx += dx;
            cy -= dy;
            acc += step;
         end else begin
            cx -= dx;
            cy += dy;
            acc -= step;
         end
      end
      acc = acc + 32768;
      return acc[31:16];
   endfunction

   function automatic rsp_type euler_angles(req_type q);
      rsp_type r;
      longint w, x, y, z;
      longint sinr, cosr, sinp, siny, cosy;
      logic [63:0] mag;
      w = q.quat_w;
      x = q.quat_x;
      y = q.quat_y;
      z = q.quat_z;
      sinr = 2 * (w * x + y * z);
      cosr = Q30 - 2 * (x * x + y * y);
      sinp = 2 * (w * y - z * x);
      siny = 2 * (w * z + x * y);
      cosy = Q30 - 2 * (y * y + z * z);
      if (sinp >= Q30 || sinp <= -Q30) begin
         r.pitch_angle = (sinp > 0) ? PITCH_POS : PITCH_NEG;
         r.pitch_saturated = 1'b1;
      end else begin
         mag = (sinp < 0) ? -sinp : sinp;
         r.pitch_angle = cordic_angle(sinp, longint'(floor_sqrt((64'd1 << 60) - mag * mag)));
         r.pitch_saturated = 1'b0;
      end
      r.roll_angle = cordic_angle(sinr, cosr);
      r.yaw_angle = cordic_angle(siny, cosy);
      return r;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, field, got,
               want);
      error_count++;
   endtask

   task automatic send_quat(req_type q);
      bit accepted;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= q;
      accepted = !busy;
      @(posedge clock);
      while (!accepted) begin
         @(negedge clock);
         accepted = !busy;
         @(posedge clock);
      end
      angles_due.insert(angles_due.size(), euler_angles(q));
      last_activity = cycle_count;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (angles_due.size() != 0) @(posedge clock);
   endtask

   function automatic req_type quat_of(int w, int x, int y, int z);
      req_type q;
      q.quat_w = w[15:0];
      q.quat_x = x[15:0];
      q.quat_y = y[15:0];
      q.quat_z = z[15:0];
      return q;
   endfunction

   function automatic real rand_real();
      return 2.0 * real'($urandom_range(1000000)) / 1000000.0 - 1.0;
   endfunction

   function automatic req_type random_quat();
      real a, b, c, d, n, s;
      int kind;
      kind = $urandom_range(9);
      if (kind < 4) begin
         return quat_of($urandom, $urandom, $urandom, $urandom);
      end
      a = rand_real();
      b = rand_real();
      c = rand_real();
      d = rand_real();
      if (kind >= 8) begin
         // Near gimbal lock: w and y dominate with equal weight.
         a = 1.0;
         c = ($urandom_range(1) != 0) ? 1.0 : -1.0;
         b = b * 0.01;
         d = d * 0.01;
      end
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0e-6) n = 1.0;
      s = 32767.0 * (0.97 + 0.06 * real'($urandom_range(1000)) / 1000.0) / n;
      if (s * n > 32767.0) s = 32767.0 / n;
      return quat_of($rtoi(a * s), $rtoi(b * s), $rtoi(c * s), $rtoi(d * s));
   endfunction

   task automatic test_directed();
      send_quat(quat_of(32767, 0, 0, 0));
      send_quat(quat_of(-32768, 0, 0, 0));
      send_quat(quat_of(0, 0, 0, 0));
      send_quat(quat_of(-32768, -32768, -32768, -32768));
      send_quat(quat_of(32767, 32767, 32767, 32767));
      send_quat(quat_of(-32768, 32767, -32768, 32767));
      send_quat(quat_of(0, -32768, 0, 0));
      send_quat(quat_of(0, 0, 0, -32768));
      send_quat(quat_of(0, 16384, 16384, 0));
      send_quat(quat_of(0, 0, 16384, 16384));
      send_quat(quat_of(23170, 0, 23170, 0));
      send_quat(quat_of(23170, 0, -23170, 0));
      send_quat(quat_of(23171, 0, 23171, 0));
      send_quat(quat_of(-23171, 0, 23171, 0));
      send_quat(quat_of(16384, 16384, 16384, -16384));
      send_quat(quat_of(0, 32767, 0, 0));
      send_quat(quat_of(0, 0, 32767, 0));
      send_quat(quat_of(23170, 23170, 0, 0));
      send_quat(quat_of(23170, 0, 0, -23170));
      send_quat(quat_of(1, -1, 1, -1));
      wait_drained();
   endtask

   task automatic test_random(int count, int idle_pct);
      send_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) send_quat(random_quat());
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe) begin
         last_activity = cycle_count;
         if (angles_due.size() == 0) begin
            $display("unexpected transaction at cycle %0d", cycle_count);
            error_count++;
         end else begin
            rsp_type want;
            want = angles_due.pop_front();
            if (rsp_data.roll_angle !== want.roll_angle)
               report_mismatch("roll_angle", rsp_data.roll_angle, want.roll_angle);
            if (rsp_data.pitch_angle !== want.pitch_angle)
               report_mismatch("pitch_angle", rsp_data.pitch_angle, want.pitch_angle);
            if (rsp_data.yaw_angle !== want.yaw_angle)
               report_mismatch("yaw_angle", rsp_data.yaw_angle, want.yaw_angle);
            if (rsp_data.pitch_saturated !== want.pitch_saturated)
               report_mismatch("pitch_saturated", rsp_data.pitch_saturated,
                               want.pitch_saturated);
         end
      end
      if (cycle_count - last_activity > IDLE_LIMIT) begin
         $display("tb_quaternion_to_euler_zyx: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      last_activity = cycle_count;
      test_directed();
      test_random(520, 17);
      wait_drained();
      test_random(520, 65);
      test_random(490, 0);
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_quaternion_to_euler_zyx: done, clean");
      end else begin
         $display("tb_quaternion_to_euler_zyx: done, errors");
      end
      $finish;
   end

endmodule
